// ===== rtl/cbed_pkg.sv =====
// Package for the chunked body end detector: parse phases, verdict codes,
// character constants, the parse state record and the hex digit decoder.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package cbed_pkg;

  localparam int SIZE_BITS = 32;
  localparam int SKIP_BITS = SIZE_BITS + 1;

  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [3:0] HEX_TEN      = 4'd10;
  localparam logic [SKIP_BITS-1:0] CRLF_LEN = SKIP_BITS'(2);

  typedef enum logic [2:0] {
    PH_SIZE_START  = 3'd0,
    PH_SIZE_DIGITS = 3'd1,
    PH_EXTENSION   = 3'd2,
    PH_DATA        = 3'd3,
    PH_TRL_START   = 3'd4,
    PH_TRL_CR      = 3'd5,
    PH_TRL_SKIP    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_NEVER    = 2'd2
  } verdict_t;

  typedef struct packed {
    phase_t                phase;
    logic [SIZE_BITS-1:0]  size_acc;
    logic [SKIP_BITS-1:0]  skip;
    verdict_t              verdict;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:    PH_SIZE_START,
    size_acc: '0,
    skip:     '0,
    verdict:  ST_PENDING
  };

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t       res;
    logic [7:0] low;
    logic [7:0] off;
    res = '0;
    low = ch | CASE_BIT;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      off = ch - CHAR_ZERO;
      res.is_hex = 1'b1;
      res.value = off[3:0];
    end else if (low >= CHAR_LOWER_A && low <= CHAR_LOWER_F) begin
      off = low - CHAR_LOWER_A;
      res.is_hex = 1'b1;
      res.value = off[3:0] + HEX_TEN;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbed_step.sv =====
// Per-byte transition of the chunked body parser: current state and one byte
// in, next state out. Pure combinational logic; depends on cbed_pkg.
`default_nettype none

module cbed_step (
  input  wire cbed_pkg::parse_state_t cur,
  input  wire                         start_of_body,
  input  wire logic [7:0]             data_byte,
  output cbed_pkg::parse_state_t      nxt
);
  import cbed_pkg::*;

  parse_state_t base;
  hex_t         hx;
  logic         acc_full;
  logic         acc_zero;
  logic         skip_last;

  always_comb begin
    base = start_of_body ? PARSE_RESET : cur;
    hx = hex_decode(data_byte);
    // Another digit would push the size past SIZE_BITS when the top nibble is in use.
    acc_full = |base.size_acc[SIZE_BITS-1 -: 4];
    acc_zero = (base.size_acc == '0);
    skip_last = (base.skip <= SKIP_BITS'(1));
    nxt = base;

    if (base.verdict == ST_PENDING) begin
      case (base.phase)
        PH_SIZE_START: begin
          if (hx.is_hex) begin
            nxt.size_acc = SIZE_BITS'(hx.value);
            nxt.phase = PH_SIZE_DIGITS;
          end else begin
            nxt.verdict = ST_NEVER;
          end
        end
        PH_SIZE_DIGITS, PH_EXTENSION: begin
          if (base.phase == PH_SIZE_DIGITS && hx.is_hex) begin
            if (acc_full) begin
              nxt.verdict = ST_NEVER;
            end else begin
              nxt.size_acc = {base.size_acc[SIZE_BITS-5:0], hx.value};
            end
          end else if (data_byte == CHAR_LF) begin
            if (acc_zero) begin
              nxt.phase = PH_TRL_START;
            end else begin
              nxt.skip = {1'b0, base.size_acc} + CRLF_LEN;
              nxt.phase = PH_DATA;
            end
          end else begin
            nxt.phase = PH_EXTENSION;
          end
        end
        PH_DATA: begin
          if (base.skip != '0) begin
            nxt.skip = base.skip - SKIP_BITS'(1);
          end
          if (skip_last) begin
            nxt.size_acc = '0;
            nxt.phase = PH_SIZE_START;
          end
        end
        PH_TRL_START: begin
          if (data_byte == CHAR_CR) begin
            nxt.phase = PH_TRL_CR;
          end else if (data_byte != CHAR_LF) begin
            nxt.phase = PH_TRL_SKIP;
          end
        end
        PH_TRL_CR: begin
          if (data_byte == CHAR_LF) begin
            nxt.verdict = ST_COMPLETE;
          end else begin
            nxt.phase = PH_TRL_SKIP;
          end
        end
        PH_TRL_SKIP: begin
          if (data_byte == CHAR_LF) begin
            nxt.phase = PH_TRL_START;
          end
        end
        default: begin
          nxt.phase = PH_SIZE_START;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chunked_body_end_detector_core.sv =====
// Top level of the chunked body end detector: parse state register, result
// register and handshakes. Depends on cbed_pkg and cbed_step.
//
// The block watches an HTTP chunked body one byte per transaction and answers
// each byte with one body_status transaction: 0 while the message is still
// pending, 1 once the terminating empty trailer line has been seen, and 2 when
// the body can never complete (a size line that does not start with a hex
// digit, or a chunk size that overflows SIZE_BITS bits). Complete and
// never-completes are sticky until a byte arrives with start_of_body set,
// which restarts the parse on that very byte. Bytes seen before the first
// start_of_body are parsed as though a body began at reset. The block takes
// one byte per cycle while no status waits on a low out_ready: the whole
// per-byte transition, including the size accumulate and the skip counter
// decrement, sits between the parse state register and the result register,
// and its status appears in the cycle after the byte is accepted. A new byte
// is accepted whenever the result register is empty or is being emptied in
// the same cycle, so there is no bubble between bytes while the consumer keeps out_ready high.
`default_nettype none

module chunked_body_end_detector_core (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              start_of_body,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [1:0]       body_status
);
  import cbed_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  logic         in_fire;

  // The result register is the only thing between the two sides, so input
  // is blocked only while a status is waiting and is not taken this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  cbed_step u_step (
    .cur           (state),
    .start_of_body (start_of_body),
    .data_byte     (data_byte),
    .nxt           (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Status payload; no reset needed since out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      body_status <= state_next.verdict;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cbed_checker.sv =====
// Port-level checker for the chunked body end detector, with its bind to the
// top level. Depends on cbed_pkg for the verdict codes.
`default_nettype none

module cbed_checker (
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire logic [1:0] body_status
);
  import cbed_pkg::*;

  // Every accepted byte produces a status in the next cycle.
  a_one_cycle_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte did not produce a status");

  // Input is only blocked by a waiting status.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // Status code is always a defined verdict.
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (body_status == ST_PENDING || body_status == ST_COMPLETE ||
                   body_status == ST_NEVER))
    else $error("undefined body status");

  // A stalled status holds.
  a_status_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(body_status))
    else $error("status changed while stalled");

endmodule

bind chunked_body_end_detector_core cbed_checker u_cbed_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .body_status (body_status)
);

`default_nettype wire
